### rtl/csi_pkg.sv
// ---------------------------------------------------------------------------
// Capsule and sphere intersection: shared types and constants
// Transaction structs, stage-to-stage records and pipeline depth figures.
// ---------------------------------------------------------------------------
package csi_pkg;

  // Fraction bits of the projection parameter t.
  localparam int T_FRAC_BITS = 32;
  // Result bits of the integer square root.
  localparam int SQRT_BITS   = 35;
  // Register stages from an accepted transaction to its result strobe.
  localparam int LATENCY     = 3 + (T_FRAC_BITS + 1) + 1 + 4 + SQRT_BITS + 1;

  // Input transaction.
  typedef struct packed {
    logic        action;
    logic [31:0] seg_start_x;
    logic [31:0] seg_start_y;
    logic [31:0] seg_start_z;
    logic [31:0] seg_end_x;
    logic [31:0] seg_end_y;
    logic [31:0] seg_end_z;
    logic [30:0] first_radius;
    logic [31:0] sphere_x;
    logic [31:0] sphere_y;
    logic [31:0] sphere_z;
    logic [30:0] sphere_radius;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic        valid_res;
    logic        intersecting;
    logic [31:0] closest_x;
    logic [31:0] closest_y;
    logic [31:0] closest_z;
    logic [32:0] center_distance;
    logic [31:0] radius_total;
  } out_t;

  // Query context carried through the projection pipeline.
  typedef struct packed {
    logic            bad;
    logic            sphere;
    logic [2:0][31:0] s;
    logic [2:0][31:0] c;
    logic [30:0]     r1;
    logic [30:0]     r2;
  } ctx_t;

  // Projection result handed to the closest-point stages.
  typedef struct packed {
    ctx_t             ctx;
    logic [2:0][32:0] seg;
    logic [T_FRAC_BITS:0] t;
  } proj_t;

  // Closest point and squared distance handed to the square root.
  typedef struct packed {
    logic             bad;
    logic             hit;
    logic [2:0][31:0] p;
    logic [31:0]      rsum;
    logic [67:0]      d2;
  } cls_t;

  // Fields that ride alongside the square-root iterations.
  typedef struct packed {
    logic             bad;
    logic             hit;
    logic [2:0][31:0] p;
    logic [31:0]      rsum;
  } sq_ctx_t;

endpackage

### rtl/csi_project.sv
// ---------------------------------------------------------------------------
// Segment projection pipeline
// Forms seg and toSphere, their dot products, then divides dot by |seg|^2
// one quotient bit per stage to give t clamped to [0,1].
// ---------------------------------------------------------------------------
module csi_project (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  csi_pkg::in_t   in_item,
  output logic           out_valid,
  output csi_pkg::proj_t out_proj
);

  localparam int N = csi_pkg::T_FRAC_BITS;

  // Division modes decided by the classify stage.
  typedef enum logic [1:0] {DIV_RUN, DIV_ZERO, DIV_ONE} div_mode_t;

  // Stage 1: differences.
  logic                   v1_r;
  csi_pkg::ctx_t          ctx1_r, ctx1_nxt;
  logic [2:0][32:0]       seg1_r, seg1_nxt, ts1_r, ts1_nxt;
  // Stage 2: products.
  logic                   v2_r;
  csi_pkg::ctx_t          ctx2_r;
  logic [2:0][32:0]       seg2_r;
  logic [2:0][65:0]       sq2_r, sq2_nxt, dt2_r, dt2_nxt;
  // Stage 3: sums.
  logic                   v3_r;
  csi_pkg::ctx_t          ctx3_r;
  logic [2:0][32:0]       seg3_r;
  logic [67:0]            len3_r, len3_nxt, dot3_r, dot3_nxt;
  // Division stages: index 0 is the classify register.
  logic                   dv_r   [0:N];
  csi_pkg::ctx_t          dctx_r [0:N];
  logic [2:0][32:0]       dseg_r [0:N];
  div_mode_t              dmode_r[0:N];
  logic [67:0]            dlen_r [0:N];
  logic [67:0]            drem_r [0:N];
  logic [N-1:0]           dq_r   [0:N];
  logic [67:0]            drem_nxt[1:N];
  logic [N-1:0]           dq_nxt  [1:N];
  csi_pkg::ctx_t          dctx0_nxt;
  div_mode_t              dmode0_nxt;
  // Output.
  logic                   vo_r;
  csi_pkg::proj_t         proj_r, proj_nxt;

  // Differences from the segment start, and the radius check.
  always_comb begin
    ctx1_nxt.bad    = (in_item.first_radius == '0) || (in_item.sphere_radius == '0);
    ctx1_nxt.sphere = in_item.action;
    ctx1_nxt.s      = {in_item.seg_start_z, in_item.seg_start_y, in_item.seg_start_x};
    ctx1_nxt.c      = {in_item.sphere_z, in_item.sphere_y, in_item.sphere_x};
    ctx1_nxt.r1     = in_item.first_radius;
    ctx1_nxt.r2     = in_item.sphere_radius;
    seg1_nxt[0] = 33'($signed(in_item.seg_end_x) - $signed(in_item.seg_start_x));
    seg1_nxt[1] = 33'($signed(in_item.seg_end_y) - $signed(in_item.seg_start_y));
    seg1_nxt[2] = 33'($signed(in_item.seg_end_z) - $signed(in_item.seg_start_z));
    ts1_nxt[0]  = 33'($signed(in_item.sphere_x) - $signed(in_item.seg_start_x));
    ts1_nxt[1]  = 33'($signed(in_item.sphere_y) - $signed(in_item.seg_start_y));
    ts1_nxt[2]  = 33'($signed(in_item.sphere_z) - $signed(in_item.seg_start_z));
  end

  // Per-axis products.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq2_nxt[i] = 66'($signed(seg1_r[i]) * $signed(seg1_r[i]));
      dt2_nxt[i] = 66'($signed(ts1_r[i]) * $signed(seg1_r[i]));
    end
  end

  // Squared length and dot product.
  always_comb begin
    len3_nxt = {2'b00, sq2_r[0]} + {2'b00, sq2_r[1]} + {2'b00, sq2_r[2]};
    dot3_nxt = {{2{dt2_r[0][65]}}, dt2_r[0]} + {{2{dt2_r[1][65]}}, dt2_r[1]}
             + {{2{dt2_r[2][65]}}, dt2_r[2]};
  end

  // Classify: degenerate segment, projection behind start or past end.
  always_comb begin
    dctx0_nxt     = ctx3_r;
    dctx0_nxt.bad = ctx3_r.bad || (!ctx3_r.sphere && (len3_r == '0));
    priority if (dot3_r[67] || (dot3_r == '0)) begin
      dmode0_nxt = DIV_ZERO;
    end else if (dot3_r >= len3_r) begin
      dmode0_nxt = DIV_ONE;
    end else begin
      dmode0_nxt = DIV_RUN;
    end
  end

  // Restoring division, one quotient bit per stage.
  always_comb begin
    logic [68:0] sh;
    sh = '0;
    for (int k = 1; k <= N; k++) begin
      sh = {drem_r[k-1], 1'b0};
      if (sh >= {1'b0, dlen_r[k-1]}) begin
        drem_nxt[k] = 68'(sh - {1'b0, dlen_r[k-1]});
        dq_nxt[k]   = {dq_r[k-1][N-2:0], 1'b1};
      end else begin
        drem_nxt[k] = sh[67:0];
        dq_nxt[k]   = {dq_r[k-1][N-2:0], 1'b0};
      end
    end
  end

  // Final t from the division mode.
  always_comb begin
    proj_nxt.ctx = dctx_r[N];
    proj_nxt.seg = dseg_r[N];
    unique case (dmode_r[N])
      DIV_ZERO: proj_nxt.t = '0;
      DIV_ONE:  proj_nxt.t = {1'b1, {N{1'b0}}};
      default:  proj_nxt.t = {1'b0, dq_r[N]};
    endcase
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
      for (int k = 0; k <= N; k++) dv_r[k] <= 1'b0;
    end else begin
      v1_r  <= in_valid;
      v2_r  <= v1_r;
      v3_r  <= v2_r;
      dv_r[0] <= v3_r;
      for (int k = 1; k <= N; k++) dv_r[k] <= dv_r[k-1];
      vo_r  <= dv_r[N];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ctx1_r <= ctx1_nxt;
    seg1_r <= seg1_nxt;
    ts1_r  <= ts1_nxt;
    ctx2_r <= ctx1_r;
    seg2_r <= seg1_r;
    sq2_r  <= sq2_nxt;
    dt2_r  <= dt2_nxt;
    ctx3_r <= ctx2_r;
    seg3_r <= seg2_r;
    len3_r <= len3_nxt;
    dot3_r <= dot3_nxt;
    dctx_r[0]  <= dctx0_nxt;
    dseg_r[0]  <= seg3_r;
    dmode_r[0] <= dmode0_nxt;
    dlen_r[0]  <= len3_r;
    drem_r[0]  <= dot3_r;
    dq_r[0]    <= '0;
    for (int k = 1; k <= N; k++) begin
      dctx_r[k]  <= dctx_r[k-1];
      dseg_r[k]  <= dseg_r[k-1];
      dmode_r[k] <= dmode_r[k-1];
      dlen_r[k]  <= dlen_r[k-1];
      drem_r[k]  <= drem_nxt[k];
      dq_r[k]    <= dq_nxt[k];
    end
    proj_r <= proj_nxt;
  end

  assign out_valid = vo_r;
  assign out_proj  = proj_r;

endmodule

### rtl/csi_closest.sv
// ---------------------------------------------------------------------------
// Closest point and squared distance
// Scales the segment by t, rounds toward minus infinity, then forms the
// squared centre distance and the exact intersection compare.
// ---------------------------------------------------------------------------
module csi_closest (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  csi_pkg::proj_t in_proj,
  output logic           out_valid,
  output csi_pkg::cls_t  out_cls
);

  localparam int N = csi_pkg::T_FRAC_BITS;

  // Stage 1: segment times t.
  logic             v1_r;
  csi_pkg::ctx_t    ctx1_r;
  logic [2:0]       neg1_r, neg1_nxt;
  logic [2:0][65:0] prod1_r, prod1_nxt;
  // Stage 2: closest point.
  logic             v2_r;
  csi_pkg::ctx_t    ctx2_r;
  logic [2:0][31:0] p2_r, p2_nxt;
  // Stage 3: squares.
  logic             v3_r;
  logic             bad3_r;
  logic [2:0][31:0] p3_r;
  logic [2:0][65:0] sq3_r, sq3_nxt;
  logic [31:0]      rsum3_r, rsum3_nxt;
  logic [63:0]      rs23_r, rs23_nxt;
  // Stage 4: sum and compare.
  logic             v4_r;
  csi_pkg::cls_t    cls4_r, cls4_nxt;

  // Magnitude of each segment axis times t.
  always_comb begin
    logic [32:0] m;
    m = '0;
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = in_proj.seg[i][32];
      m = in_proj.seg[i][32] ? 33'(-in_proj.seg[i]) : in_proj.seg[i];
      prod1_nxt[i] = 66'(m * in_proj.t);
    end
  end

  // Offset from start, rounded toward minus infinity for negative axes.
  always_comb begin
    logic [33:0] q;
    q = '0;
    for (int i = 0; i < 3; i++) begin
      q = prod1_r[i][65:N];
      if (ctx1_r.sphere) begin
        p2_nxt[i] = ctx1_r.s[i];
      end else if (neg1_r[i]) begin
        q = q + {33'd0, (prod1_r[i][N-1:0] != '0)};
        p2_nxt[i] = 32'(ctx1_r.s[i] - q[31:0]);
      end else begin
        p2_nxt[i] = 32'(ctx1_r.s[i] + q[31:0]);
      end
    end
  end

  // Squared axis distances and squared radius sum.
  always_comb begin
    logic signed [32:0] d;
    logic [32:0]        m;
    d = '0;
    m = '0;
    for (int i = 0; i < 3; i++) begin
      d = 33'($signed(p2_r[i]) - $signed(ctx2_r.c[i]));
      m = d[32] ? 33'(-d) : d;
      sq3_nxt[i] = 66'(m * m);
    end
    rsum3_nxt = {1'b0, ctx2_r.r1} + {1'b0, ctx2_r.r2};
    rs23_nxt  = 64'(rsum3_nxt * rsum3_nxt);
  end

  // Squared distance and the intersection test.
  always_comb begin
    cls4_nxt.bad  = bad3_r;
    cls4_nxt.p    = p3_r;
    cls4_nxt.rsum = rsum3_r;
    cls4_nxt.d2   = {2'b00, sq3_r[0]} + {2'b00, sq3_r[1]} + {2'b00, sq3_r[2]};
    cls4_nxt.hit  = (cls4_nxt.d2 <= {4'd0, rs23_r});
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ctx1_r  <= in_proj.ctx;
    neg1_r  <= neg1_nxt;
    prod1_r <= prod1_nxt;
    ctx2_r  <= ctx1_r;
    p2_r    <= p2_nxt;
    bad3_r  <= ctx2_r.bad;
    p3_r    <= p2_r;
    sq3_r   <= sq3_nxt;
    rsum3_r <= rsum3_nxt;
    rs23_r  <= rs23_nxt;
    cls4_r  <= cls4_nxt;
  end

  assign out_valid = v4_r;
  assign out_cls   = cls4_r;

endmodule

### rtl/csi_sqrt.sv
// ---------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit root of the squared distance, one result bit per stage,
// with the query fields riding alongside.
// ---------------------------------------------------------------------------
module csi_sqrt (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  csi_pkg::cls_t    in_cls,
  output logic             out_valid,
  output csi_pkg::sq_ctx_t out_ctx,
  output logic [32:0]      out_root
);

  localparam int B = csi_pkg::SQRT_BITS;

  logic             v_r   [1:B];
  csi_pkg::sq_ctx_t ctx_r [1:B];
  logic [71:0]      rem_r [1:B];
  logic [B-1:0]     res_r [1:B];
  logic [71:0]      rem_nxt[1:B];
  logic [B-1:0]     res_nxt[1:B];
  csi_pkg::sq_ctx_t ctx0;

  assign ctx0 = '{bad: in_cls.bad, hit: in_cls.hit, p: in_cls.p, rsum: in_cls.rsum};

  // Stage k settles result bit B-k: keep rem = n - res^2.
  always_comb begin
    logic [71:0]  rem_in;
    logic [B-1:0] res_in;
    logic [71:0]  trial;
    rem_in = '0;
    res_in = '0;
    trial  = '0;
    for (int k = 1; k <= B; k++) begin
      if (k == 1) begin
        rem_in = {4'd0, in_cls.d2};
        res_in = '0;
      end else begin
        rem_in = rem_r[k-1];
        res_in = res_r[k-1];
      end
      trial = ({{(72-B){1'b0}}, res_in} << (B - k + 1)) | (72'd1 << (2 * (B - k)));
      if (trial <= rem_in) begin
        rem_nxt[k] = rem_in - trial;
        res_nxt[k] = res_in | (B'(1) << (B - k));
      end else begin
        rem_nxt[k] = rem_in;
        res_nxt[k] = res_in;
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= B; k++) v_r[k] <= 1'b0;
    end else begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= B; k++) v_r[k] <= v_r[k-1];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    ctx_r[1] <= ctx0;
    for (int k = 2; k <= B; k++) ctx_r[k] <= ctx_r[k-1];
    for (int k = 1; k <= B; k++) begin
      rem_r[k] <= rem_nxt[k];
      res_r[k] <= res_nxt[k];
    end
  end

  assign out_valid = v_r[B];
  assign out_ctx   = ctx_r[B];
  assign out_root  = 33'(res_r[B]);

endmodule

### rtl/capsule_sphere_intersection.sv
// Throughput: one transaction per cycle; every stage is a full register stage.
//   The latency is set by the 33 divider stages for t and the 35-stage square root.
// busy is held low: a transaction may start in every cycle.
// Reset: synchronous active-low rst_n clears every valid bit; data stays.
// ---------------------------------------------------------------------------
// Capsule and sphere intersection top level
// Projection, closest point and square-root pipelines, then a result register.
// ---------------------------------------------------------------------------
module capsule_sphere_intersection (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  csi_pkg::in_t  in_item,
  output logic          out_strobe,
  output csi_pkg::out_t out_item
);

  logic             accept;
  logic             pv, cv, sv;
  csi_pkg::proj_t   proj;
  csi_pkg::cls_t    cls;
  csi_pkg::sq_ctx_t sctx;
  logic [32:0]      root;
  logic             strobe_r;
  csi_pkg::out_t    res_r, res_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  csi_project u_project (
    .clk(clk), .rst_n(rst_n), .in_valid(accept), .in_item(in_item),
    .out_valid(pv), .out_proj(proj)
  );

  csi_closest u_closest (
    .clk(clk), .rst_n(rst_n), .in_valid(pv), .in_proj(proj),
    .out_valid(cv), .out_cls(cls)
  );

  csi_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .in_valid(cv), .in_cls(cls),
    .out_valid(sv), .out_ctx(sctx), .out_root(root)
  );

  // Invalid queries report all-zero fields.
  always_comb begin
    if (sctx.bad) begin
      res_nxt = '0;
    end else begin
      res_nxt.valid_res       = 1'b1;
      res_nxt.intersecting    = sctx.hit;
      res_nxt.closest_x       = sctx.p[0];
      res_nxt.closest_y       = sctx.p[1];
      res_nxt.closest_z       = sctx.p[2];
      res_nxt.center_distance = root;
      res_nxt.radius_total    = sctx.rsum;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= sv;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_item   = res_r;

endmodule

### rtl/csi_checker.sv
// ---------------------------------------------------------------------------
// Port checker for the intersection block
// Checks result timing and the shape of reported results at the ports.
// ---------------------------------------------------------------------------
module csi_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input csi_pkg::out_t out_item
);

  // Every accepted transaction yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(csi_pkg::LATENCY) out_strobe)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##(csi_pkg::LATENCY) !out_strobe)
    else $error("result without a transaction");

  // An invalid result carries only zero fields.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.valid_res) |-> (out_item == '0))
    else $error("invalid result carries non-zero fields");

  // Intersection is only reported for valid queries.
  a_hit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.intersecting) |-> out_item.valid_res)
    else $error("intersection flagged on an invalid result");

endmodule

bind capsule_sphere_intersection csi_checker u_csi_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_item(out_item)
);
